// ===== design/assert_macros.svh =====
// Assertion shorthands shared by the RTL. All of them sample on clk_i and
// are held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define POT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// pre implies post in the same cycle
`define POT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// pre implies post in the next cycle
`define POT_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/pot_pkg.sv =====
package pot_pkg;

  localparam int unsigned MAX_PAGES       = 4096;
  localparam int unsigned CHUNK_PAGES     = 64;
  localparam int unsigned MAX_OWNER_SLOTS = 64;
  localparam int unsigned NUM_CHUNKS      = (MAX_PAGES + CHUNK_PAGES - 1) / CHUNK_PAGES;
  localparam int unsigned PAGE_AW         = $clog2(MAX_PAGES);
  localparam int unsigned SLOT_AW         = $clog2(MAX_OWNER_SLOTS);
  localparam int unsigned CHUNK_AW        = $clog2(NUM_CHUNKS);
  localparam int unsigned QDEPTH          = 2;

  localparam logic [7:0]  NO_SLOT   = 8'hff;
  localparam logic [12:0] PAGES_RST = 13'd4096;
  localparam logic [6:0]  SLOTS_RST = 7'd64;

  // config register indexes
  localparam logic CFG_PAGES = 1'b0;
  localparam logic CFG_SLOTS = 1'b1;

  typedef enum logic [2:0] {
    FN_ALLOC   = 3'd0,
    FN_FREE    = 3'd1,
    FN_COMMIT  = 3'd2,
    FN_CHECK   = 3'd3,
    FN_RELEASE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_BAD_OP    = 3'd5
  } status_e;

  // work the back end has to do; CMD_REPLY answers with the status set by the front end
  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_COMMIT  = 3'd2,
    CMD_CHECK   = 3'd3,
    CMD_RELEASE = 3'd4,
    CMD_REPLY   = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    status_e     status;
    logic [15:0] tag;
    logic [11:0] first;
    logic [12:0] count;
    logic [12:0] last;   // first + count, valid for alloc / free
  } cmd_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] gen;
  } page_ent_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [31:0] gen;
    logic [12:0] refs;
  } slot_ent_t;

  typedef struct packed {
    logic [63:0] seq;
    logic        in_range;
    logic        owned;
    logic [5:0]  slot;
    status_e     status;
  } result_t;

endpackage

// ===== design/pot_ram.sv =====
module pot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pot_front.sv =====
module pot_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,
  input  logic [2:0]    s_axis_tuser,
  input  logic          init_done_i,
  input  logic [12:0]   np_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output pot_pkg::cmd_t cmd_o
);

  localparam int unsigned PW = $clog2(pot_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(pot_pkg::QDEPTH + 1);

  logic [15:0]   tag;
  logic [11:0]   first;
  logic [12:0]   count;
  logic [13:0]   last_w;
  pot_pkg::cmd_t cls;
  logic          push, pop;

  pot_pkg::cmd_t q_q [pot_pkg::QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign tag    = s_axis_tdata[15:0];
  assign first  = s_axis_tdata[27:16];
  assign count  = s_axis_tdata[40:28];
  assign last_w = {2'b00, first} + {1'b0, count};

  // classify: range checks are settled here, the back end only walks
  always_comb begin
    cls        = '0;
    cls.kind   = pot_pkg::CMD_REPLY;
    cls.status = pot_pkg::ST_OK;
    cls.tag    = tag;
    cls.first  = first;
    cls.count  = count;
    cls.last   = last_w[12:0];
    case (s_axis_tuser)
      pot_pkg::FN_ALLOC, pot_pkg::FN_FREE: begin
        if (count != 13'd0) begin
          if (last_w > {1'b0, np_i}) begin
            cls.status = pot_pkg::ST_RANGE;
          end else if (s_axis_tuser == pot_pkg::FN_ALLOC) begin
            cls.kind = pot_pkg::CMD_ALLOC;
          end else begin
            cls.kind = pot_pkg::CMD_FREE;
          end
        end
      end
      pot_pkg::FN_COMMIT: begin
        cls.kind = pot_pkg::CMD_COMMIT;
      end
      pot_pkg::FN_CHECK: begin
        if ({1'b0, first} < np_i) begin
          cls.kind = pot_pkg::CMD_CHECK;
        end else begin
          cls.status = pot_pkg::ST_RANGE;
        end
      end
      pot_pkg::FN_RELEASE: begin
        cls.kind = pot_pkg::CMD_RELEASE;
      end
      default: begin
        cls.status = pot_pkg::ST_BAD_OP;
      end
    endcase
  end

  assign s_axis_tready = init_done_i && (cnt_q != CW'(pot_pkg::QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != '0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = q_q[rd_q];

  always_comb begin
    wr_d  = push ? PW'(wr_q + PW'(1)) : wr_q;
    rd_d  = pop  ? PW'(rd_q + PW'(1)) : rd_q;
    cnt_d = CW'(cnt_q + CW'(push) - CW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cls;
    end
  end

endmodule

// ===== design/pot_back.sv =====
`include "assert_macros.svh"

module pot_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  pot_pkg::cmd_t cmd_i,
  input  logic [12:0]   np_i,
  input  logic [6:0]    ns_i,
  output logic          init_done_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [79:0]   m_axis_tdata
);

  localparam int unsigned PAW = pot_pkg::PAGE_AW;
  localparam int unsigned SAW = pot_pkg::SLOT_AW;
  localparam int unsigned NCH = pot_pkg::NUM_CHUNKS;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PG_RD   = 4'd2;
  localparam logic [3:0] S_PG_EV   = 4'd3;
  localparam logic [3:0] S_SL_EV   = 4'd4;
  localparam logic [3:0] S_SCAN_RD = 4'd5;
  localparam logic [3:0] S_SCAN_EV = 4'd6;
  localparam logic [3:0] S_AL_WR   = 4'd7;
  localparam logic [3:0] S_COMMIT  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0]        st_q, st_d;
  logic              pass_q, pass_d;
  logic [12:0]       idx_q, idx_d;
  logic [NCH-1:0]    dirty_q, dirty_d;
  logic [63:0]       seq_q, seq_d;
  logic              out_vld_q, out_vld_d;

  pot_pkg::cmd_t     cmd_q, cmd_d;
  logic [6:0]        sidx_q, sidx_d;
  logic              free_vld_q, free_vld_d;
  logic [SAW-1:0]    free_idx_q, free_idx_d;
  logic [31:0]       free_gen_q, free_gen_d;
  logic [SAW-1:0]    sel_q, sel_d;
  logic [31:0]       agen_q, agen_d;
  logic [31:0]       pgen_q, pgen_d;
  logic [7:0]        pslot_q, pslot_d;
  pot_pkg::status_e  status_q, status_d;
  logic [5:0]        slot_out_q, slot_out_d;
  logic              owned_q, owned_d, inr_q, inr_d;
  logic [63:0]       seqo_q, seqo_d;
  logic [79:0]       out_q, out_d;

  logic                pg_we, pg_re;
  logic [PAW-1:0]      pg_waddr, pg_raddr;
  pot_pkg::page_ent_t  pg_wdata, pd;
  logic                sl_we, sl_re;
  logic [SAW-1:0]      sl_waddr, sl_raddr;
  pot_pkg::slot_ent_t  sl_wdata, sd;

  pot_ram #(
    .WIDTH ($bits(pot_pkg::page_ent_t)),
    .DEPTH (pot_pkg::MAX_PAGES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (pg_wdata),
    .re_i    (pg_re),
    .raddr_i (pg_raddr),
    .rdata_o (pd)
  );

  pot_ram #(
    .WIDTH ($bits(pot_pkg::slot_ent_t)),
    .DEPTH (pot_pkg::MAX_OWNER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .re_i    (sl_re),
    .raddr_i (sl_raddr),
    .rdata_o (sd)
  );

  // per-page helpers
  localparam int unsigned CHUNK_AW_W = pot_pkg::CHUNK_AW;
  logic [12:0]        idx_nx, range_end;
  logic               last_pg, slot_ok, owns_w;
  logic [CHUNK_AW_W-1:0] chunk_w;
  logic [12:0]        refs_dec;
  pot_pkg::slot_ent_t drop_ent;
  pot_pkg::page_ent_t clr_ent;
  // slot scan helpers
  logic [6:0]         sidx_nx;
  logic               scan_last, sl_hit, free_here;
  logic [31:0]        gen_base, gen_inc;
  pot_pkg::result_t   res;
  // walk advance
  logic [3:0]         adv_st;
  logic [12:0]        adv_idx;
  logic               adv_pass;

  assign idx_nx    = idx_q + 13'd1;
  assign range_end = (cmd_q.kind == pot_pkg::CMD_RELEASE) ? np_i : cmd_q.last;
  assign last_pg   = (idx_nx == range_end);
  assign chunk_w   = CHUNK_AW_W'(idx_q[PAW-1:0] / pot_pkg::CHUNK_PAGES);
  assign slot_ok   = (pd.slot != pot_pkg::NO_SLOT) && (pd.slot < {1'b0, ns_i});
  assign owns_w    = sd.valid && (sd.tag == cmd_q.tag) && (sd.gen == pgen_q);
  assign refs_dec  = (sd.refs != 13'd0) ? 13'(sd.refs - 13'd1) : 13'd0;

  always_comb begin
    drop_ent       = sd;
    drop_ent.refs  = refs_dec;
    if (refs_dec == 13'd0) begin
      drop_ent.valid = 1'b0;
      drop_ent.tag   = '0;
    end
    clr_ent      = '0;
    clr_ent.slot = pot_pkg::NO_SLOT;
  end

  assign sidx_nx   = sidx_q + 7'd1;
  assign scan_last = (sidx_nx == ns_i);
  assign sl_hit    = sd.valid && (sd.tag == cmd_q.tag);
  assign free_here = !sd.valid && !free_vld_q;
  assign gen_base  = free_here ? sd.gen : free_gen_q;
  assign gen_inc   = ((gen_base + 32'd1) == 32'd0) ? 32'd1 : 32'(gen_base + 32'd1);

  // next step of a page walk (free passes and release)
  always_comb begin
    adv_st   = S_PG_RD;
    adv_idx  = idx_nx;
    adv_pass = pass_q;
    if (last_pg) begin
      if (cmd_q.kind == pot_pkg::CMD_RELEASE) begin
        adv_st = S_COMMIT;
      end else if (!pass_q) begin
        adv_pass = 1'b1;
        adv_idx  = {1'b0, cmd_q.first};
      end else begin
        adv_st = S_OUT;
      end
    end
  end

  always_comb begin
    res.seq      = seqo_q;
    res.in_range = inr_q;
    res.owned    = owned_q;
    res.slot     = slot_out_q;
    res.status   = status_q;
  end

  always_comb begin
    st_d       = st_q;
    pass_d     = pass_q;
    idx_d      = idx_q;
    dirty_d    = dirty_q;
    seq_d      = seq_q;
    out_vld_d  = out_vld_q;
    cmd_d      = cmd_q;
    sidx_d     = sidx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    free_gen_d = free_gen_q;
    sel_d      = sel_q;
    agen_d     = agen_q;
    pgen_d     = pgen_q;
    pslot_d    = pslot_q;
    status_d   = status_q;
    slot_out_d = slot_out_q;
    owned_d    = owned_q;
    inr_d      = inr_q;
    seqo_d     = seqo_q;
    out_d      = out_q;

    pg_we    = 1'b0;
    pg_waddr = idx_q[PAW-1:0];
    pg_wdata = clr_ent;
    pg_re    = 1'b0;
    pg_raddr = idx_q[PAW-1:0];
    sl_we    = 1'b0;
    sl_waddr = pslot_q[SAW-1:0];
    sl_wdata = drop_ent;
    sl_re    = 1'b0;
    sl_raddr = pd.slot[SAW-1:0];

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (st_q)
      S_CLR: begin
        pg_we = 1'b1;
        if (idx_q < 13'(pot_pkg::MAX_OWNER_SLOTS)) begin
          sl_we    = 1'b1;
          sl_waddr = idx_q[SAW-1:0];
          sl_wdata = '0;
        end
        idx_d = idx_nx;
        if (idx_nx == 13'(pot_pkg::MAX_PAGES)) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d      = cmd_i;
          status_d   = pot_pkg::ST_OK;
          slot_out_d = '0;
          owned_d    = 1'b0;
          inr_d      = 1'b0;
          seqo_d     = '0;
          pass_d     = 1'b0;
          idx_d      = {1'b0, cmd_i.first};
          case (cmd_i.kind)
            pot_pkg::CMD_ALLOC, pot_pkg::CMD_FREE: begin
              st_d = S_PG_RD;
            end
            pot_pkg::CMD_CHECK: begin
              inr_d = 1'b1;
              st_d  = S_PG_RD;
            end
            pot_pkg::CMD_RELEASE: begin
              idx_d = '0;
              st_d  = (np_i == 13'd0) ? S_COMMIT : S_PG_RD;
            end
            pot_pkg::CMD_COMMIT: begin
              st_d = S_COMMIT;
            end
            pot_pkg::CMD_REPLY: begin
              status_d = cmd_i.status;
              st_d     = S_OUT;
            end
            default: begin
              status_d = pot_pkg::ST_BAD_OP;
              st_d     = S_OUT;
            end
          endcase
        end
      end
      S_PG_RD: begin
        pg_re = 1'b1;
        st_d  = S_PG_EV;
      end
      S_PG_EV: begin
        pslot_d = pd.slot;
        pgen_d  = pd.gen;
        if (cmd_q.kind == pot_pkg::CMD_ALLOC) begin
          if (pd.slot != pot_pkg::NO_SLOT) begin
            status_d = pot_pkg::ST_BUSY;
            st_d     = S_OUT;
          end else if (!last_pg) begin
            idx_d = idx_nx;
            st_d  = S_PG_RD;
          end else if (ns_i == 7'd0) begin
            status_d = pot_pkg::ST_NO_SLOT;
            st_d     = S_OUT;
          end else begin
            sidx_d     = '0;
            free_vld_d = 1'b0;
            st_d       = S_SCAN_RD;
          end
        end else if (slot_ok) begin
          sl_re = 1'b1;
          st_d  = S_SL_EV;
        end else if (cmd_q.kind == pot_pkg::CMD_CHECK) begin
          st_d = S_OUT;
        end else if (cmd_q.kind == pot_pkg::CMD_FREE && !pass_q) begin
          status_d = pot_pkg::ST_NOT_OWNER;
          st_d     = S_OUT;
        end else begin
          // second free pass drops the page even without a slot behind it
          if (cmd_q.kind == pot_pkg::CMD_FREE) begin
            pg_we            = 1'b1;
            dirty_d[chunk_w] = 1'b1;
          end
          st_d   = adv_st;
          idx_d  = adv_idx;
          pass_d = adv_pass;
        end
      end
      S_SL_EV: begin
        if (cmd_q.kind == pot_pkg::CMD_CHECK) begin
          owned_d = owns_w;
          st_d    = S_OUT;
        end else if (cmd_q.kind == pot_pkg::CMD_FREE && !pass_q && !owns_w) begin
          status_d = pot_pkg::ST_NOT_OWNER;
          st_d     = S_OUT;
        end else begin
          if (pass_q || (cmd_q.kind == pot_pkg::CMD_RELEASE && owns_w)) begin
            pg_we            = 1'b1;
            sl_we            = 1'b1;
            dirty_d[chunk_w] = 1'b1;
          end
          st_d   = adv_st;
          idx_d  = adv_idx;
          pass_d = adv_pass;
        end
      end
      S_SCAN_RD: begin
        sl_re    = 1'b1;
        sl_raddr = sidx_q[SAW-1:0];
        st_d     = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        idx_d = {1'b0, cmd_q.first};
        if (sl_hit) begin
          sl_we         = 1'b1;
          sl_waddr      = sidx_q[SAW-1:0];
          sl_wdata      = sd;
          sl_wdata.refs = 13'(sd.refs + cmd_q.count);
          sel_d         = sidx_q[SAW-1:0];
          agen_d        = sd.gen;
          st_d          = S_AL_WR;
        end else begin
          if (free_here) begin
            free_vld_d = 1'b1;
            free_idx_d = sidx_q[SAW-1:0];
            free_gen_d = sd.gen;
          end
          if (!scan_last) begin
            sidx_d = sidx_nx;
            st_d   = S_SCAN_RD;
          end else if (free_here || free_vld_q) begin
            sl_we          = 1'b1;
            sl_waddr       = free_here ? sidx_q[SAW-1:0] : free_idx_q;
            sl_wdata.valid = 1'b1;
            sl_wdata.tag   = cmd_q.tag;
            sl_wdata.gen   = gen_inc;
            sl_wdata.refs  = cmd_q.count;
            sel_d          = sl_waddr;
            agen_d         = gen_inc;
            st_d           = S_AL_WR;
          end else begin
            status_d = pot_pkg::ST_NO_SLOT;
            st_d     = S_OUT;
          end
        end
      end
      S_AL_WR: begin
        pg_we            = 1'b1;
        pg_wdata.slot    = 8'(sel_q);
        pg_wdata.gen     = agen_q;
        dirty_d[chunk_w] = 1'b1;
        if (last_pg) begin
          slot_out_d = 6'(sel_q);
          st_d       = S_OUT;
        end else begin
          idx_d = idx_nx;
        end
      end
      S_COMMIT: begin
        if (dirty_q != '0) begin
          seq_d   = seq_q + 64'd1;
          seqo_d  = seq_q + 64'd1;
          dirty_d = '0;
        end
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d     = {5'b0, res};
          out_vld_d = 1'b1;
          st_d      = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLR;
      pass_q    <= 1'b0;
      idx_q     <= '0;
      dirty_q   <= '0;
      seq_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      pass_q    <= pass_d;
      idx_q     <= idx_d;
      dirty_q   <= dirty_d;
      seq_q     <= seq_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    sidx_q     <= sidx_d;
    free_vld_q <= free_vld_d;
    free_idx_q <= free_idx_d;
    free_gen_q <= free_gen_d;
    sel_q      <= sel_d;
    agen_q     <= agen_d;
    pgen_q     <= pgen_d;
    pslot_q    <= pslot_d;
    status_q   <= status_d;
    slot_out_q <= slot_out_d;
    owned_q    <= owned_d;
    inr_q      <= inr_d;
    seqo_q     <= seqo_d;
    out_q      <= out_d;
  end

  assign cmd_ready_o   = (st_q == S_IDLE);
  assign init_done_o   = (st_q != S_CLR);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `POT_ASSERT_NXT(a_commit_clears_dirty, st_q == S_COMMIT, dirty_q == '0,
    "dirty mask survived a commit")
  `POT_ASSERT_NXT(a_seq_step, (st_q == S_COMMIT) && (dirty_q != '0),
    (seq_q == $past(seq_q) + 64'd1) && (seqo_q == seq_q), "sequence did not advance by one")
  `POT_ASSERT_IMP(a_alloc_slot_in_use, st_q == S_AL_WR, {1'b0, sel_q} < ns_i,
    "page written with a slot outside the usable range")
  `POT_ASSERT_IMP(a_busy_from_alloc, (st_q == S_OUT) && (status_q == pot_pkg::ST_BUSY),
    cmd_q.kind == pot_pkg::CMD_ALLOC, "busy status on a non-allocate word")

endmodule

// ===== design/page_ownership_table_core.sv =====
// Page ownership table. Each input word (tuser = func, tdata = owner tag,
// first page, page count) gives exactly one result word, in order. A front
// end classifies words (range checks, bad codes) into a two-entry command
// queue; a back end walks the page table and the owner-slot table, both
// RAMs with one write port and one registered read port. After reset a
// clearing pass marks every page unowned, no word is accepted meanwhile.
// Replies (zero count, out of range, bad code) go straight to the output.
// Allocate checks each page, scans the owner slots and then writes each page;
// free walks the pages in two passes (check, then drop); release walks every
// page below pages_in_use, then commits. The back end takes the next word
// only when it is done with the last. Each page of a walk needs the page read
// followed by the dependent slot read.
// Configuration writes (cfg_idx_i 0 = pages_in_use, 1 = owner_slots_in_use)
// take effect at once and belong between words, while the block is idle.
module page_ownership_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // owner_id[15:0], first_page[27:16], page_count[40:28]
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // status[2:0], slot_used[8:3], owner_match[9],
                                      // page_in_range[10], commit_sequence[74:11]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  logic [12:0]   pages_q;
  logic [6:0]    slots_q;
  logic [12:0]   np;      // effective page count
  logic [6:0]    ns;      // effective slot count
  logic          init_done;
  logic          cmd_valid, cmd_ready;
  pot_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= pot_pkg::PAGES_RST;
      slots_q <= pot_pkg::SLOTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pot_pkg::CFG_PAGES: pages_q <= cfg_data_i;
        pot_pkg::CFG_SLOTS: slots_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // clamp to what the tables hold
  assign np = (pages_q > 13'(pot_pkg::MAX_PAGES)) ? 13'(pot_pkg::MAX_PAGES) : pages_q;
  assign ns = (slots_q > 7'(pot_pkg::MAX_OWNER_SLOTS)) ? 7'(pot_pkg::MAX_OWNER_SLOTS)
                                                       : slots_q;

  pot_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .init_done_i   (init_done),
    .np_i          (np),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  pot_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .np_i          (np),
    .ns_i          (ns),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
